// ----- rtl/core/fma_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fma_pkg: shared definitions of the fit memory allocator
// Field widths, stream packing, command and mode codes, sequencer states.
// ----------------------------------------------------------------------------
package fma_pkg;

	// default sizing of the partition table
	localparam int unsigned MAX_BLOCKS_DEF = 64;
	localparam int unsigned SIZE_BITS_DEF  = 16;

	// request fields
	localparam int unsigned FUNC_BITS  = 2;
	localparam int unsigned INDEX_BITS = 6;
	localparam int unsigned SIZEF_BITS = 16;

	// configuration registers
	localparam int unsigned MODE_BITS     = 2;
	localparam int unsigned COUNT_BITS    = 7;
	localparam int unsigned CFG_ADDR_BITS = 1;
	localparam int unsigned CFG_DATA_BITS = 7;
	localparam logic [COUNT_BITS-1:0] BLOCK_COUNT_RST = 7'd64;

	// stream packing, lowest field first, padded to whole bytes
	localparam int unsigned IN_FUNC_LSB   = 0;
	localparam int unsigned IN_INDEX_LSB  = IN_FUNC_LSB + FUNC_BITS;
	localparam int unsigned IN_SIZE_LSB   = IN_INDEX_LSB + INDEX_BITS;
	localparam int unsigned IN_USED_BITS  = IN_SIZE_LSB + SIZEF_BITS;
	localparam int unsigned IN_DATA_BITS  = ((IN_USED_BITS + 7) / 8) * 8;
	localparam int unsigned OUT_USED_BITS = 1 + INDEX_BITS + SIZEF_BITS;
	localparam int unsigned OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

	typedef enum logic [FUNC_BITS-1:0] {
		FUNC_LOAD    = 2'd0,
		FUNC_ALLOC   = 2'd1,
		FUNC_RESTORE = 2'd2
	} func_t;

	typedef enum logic [MODE_BITS-1:0] {
		MODE_FIRST = 2'd0,
		MODE_BEST  = 2'd1,
		MODE_WORST = 2'd2
	} mode_t;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_FIT_MODE    = 1'd0,
		REG_BLOCK_COUNT = 1'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COPY,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/core/fit_memory_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_memory_allocator: first / best / worst fit partition allocator
// Partition size table with a sequencer that scans it through one comparator.
// ----------------------------------------------------------------------------
// Usage:
//  - s_* stream takes one request at a time: load a partition size, allocate
//    space, or restore all remaining sizes from the original sizes.
//  - m_* stream returns exactly one result per request (granted flag, chosen
//    partition, space left). Non-allocate requests return all zeros.
//  - cfg_* writes fit_mode (index 0) and block_count (index 1); the user
//    must write them only while idle, which the block itself does not enforce.
// Sequencing:
//  - load: table written on acceptance; result registered in the done step.
//  - allocate: block_count (saturated to MAX_BLOCKS) entries are scanned;
//    the scan reads one free-size entry per cycle from the single memory
//    read port and feeds one shared compare unit.
//  - restore: all MAX_BLOCKS entries, one entry copied per cycle.
//  s_tready is high only while the sequencer is idle. A finished result sits
//  in the output register; the next request can be accepted while it waits,
//  and a stalled receiver only holds the sequencer in its final step.
// Reset: fit_mode = first fit, block_count = 64, no result pending. The
// partition memories are not cleared; an entry must be loaded before use.
// ----------------------------------------------------------------------------
module fit_memory_allocator
	import fma_pkg::*;
#(
	parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF,
	parameter int unsigned SIZE_BITS  = SIZE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// request stream
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IN_DATA_BITS-1:0]  s_tdata,   // func[1:0], block_index[7:2], size_value[23:8]
	// result stream
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_DATA_BITS-1:0] m_tdata,   // granted[0], chosen_block[6:1],
	                                            // remaining_size[22:7], zero pad
	// configuration write port
	input  logic                     cfg_we,
	input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

	localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
	localparam int unsigned KW = (CW > COUNT_BITS) ? CW : COUNT_BITS;
	localparam int unsigned VW = (SIZE_BITS > SIZEF_BITS) ? SIZE_BITS : SIZEF_BITS;
	localparam int unsigned IW = (CW > INDEX_BITS) ? CW : INDEX_BITS;

	// ------------------------------------------------------------------
	// request unpacking
	// ------------------------------------------------------------------
	logic                  s_acc;
	logic [FUNC_BITS-1:0]  in_func;
	logic [INDEX_BITS-1:0] in_index;
	logic [SIZEF_BITS-1:0] in_size;
	logic [IW-1:0]         in_index_ext;
	logic [VW-1:0]         in_size_ext;
	logic                  load_ok;
	logic [AW-1:0]         load_addr;
	logic [SIZE_BITS-1:0]  load_wd;

	assign in_func      = s_tdata[IN_FUNC_LSB +: FUNC_BITS];
	assign in_index     = s_tdata[IN_INDEX_LSB +: INDEX_BITS];
	assign in_size      = s_tdata[IN_SIZE_LSB +: SIZEF_BITS];
	assign in_index_ext = IW'(in_index);
	assign in_size_ext  = VW'(in_size);
	assign load_ok      = (in_index_ext < IW'(MAX_BLOCKS));
	assign load_addr    = in_index_ext[AW-1:0];
	assign load_wd      = in_size_ext[SIZE_BITS-1:0];

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [MODE_BITS-1:0]  fit_mode_q;
	logic [COUNT_BITS-1:0] block_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q    <= MODE_FIRST;
			block_count_q <= BLOCK_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_FIT_MODE:    fit_mode_q    <= cfg_wdata[MODE_BITS-1:0];
				REG_BLOCK_COUNT: block_count_q <= cfg_wdata[COUNT_BITS-1:0];
				default:         ;
			endcase
		end
	end

	// block_count above the table depth is clamped to the depth
	logic [KW-1:0] bc_ext;
	logic [CW-1:0] scan_count;

	assign bc_ext = KW'(block_count_q);
	always_comb begin
		if (bc_ext > KW'(MAX_BLOCKS)) begin
			scan_count = CW'(MAX_BLOCKS);
		end else begin
			scan_count = bc_ext[CW-1:0];
		end
	end

	// ------------------------------------------------------------------
	// sequencer and datapath registers
	// ------------------------------------------------------------------
	state_t               state_q, state_d;
	logic [CW-1:0]        issue_q;      // next entry to read
	logic [CW-1:0]        limit_q;      // entries to read this pass
	logic                 vld_s1;       // read data valid this cycle
	logic [AW-1:0]        idx_s1;       // entry of the read data
	logic [VW-1:0]        req_q;        // requested size
	logic                 found_q;
	logic [AW-1:0]        pick_q;
	logic [SIZE_BITS-1:0] pick_val_q;
	logic                 m_tvalid_q;
	logic [OUT_DATA_BITS-1:0] m_tdata_q;

	// memories
	logic [SIZE_BITS-1:0] free_mem [MAX_BLOCKS];
	logic [SIZE_BITS-1:0] orig_mem [MAX_BLOCKS];
	logic [SIZE_BITS-1:0] free_rd_q;
	logic [SIZE_BITS-1:0] orig_rd_q;

	logic                 issue_go;
	logic                 out_load;
	logic                 free_we;
	logic [AW-1:0]        free_wa;
	logic [SIZE_BITS-1:0] free_wd;
	logic                 orig_we;
	logic [SIZE_BITS-1:0] new_val;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign orig_we  = s_acc && (in_func == FUNC_LOAD) && load_ok;
	assign new_val  = pick_val_q - req_q[SIZE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		issue_go = 1'b0;
		out_load = 1'b0;
		free_we  = 1'b0;
		free_wa  = load_addr;
		free_wd  = load_wd;
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					unique case (in_func)
						FUNC_LOAD: begin
							free_we = load_ok;
							state_d = ST_DONE;
						end
						FUNC_ALLOC:   state_d = ST_SCAN;
						FUNC_RESTORE: state_d = ST_COPY;
						default:      state_d = ST_DONE;
					endcase
				end
			end
			ST_SCAN: begin
				issue_go = (issue_q != limit_q);
				if (!issue_go && !vld_s1) begin
					state_d = ST_DONE;
				end
			end
			ST_COPY: begin
				issue_go = (issue_q != limit_q);
				free_we  = vld_s1;
				free_wa  = idx_s1;
				free_wd  = orig_rd_q;
				if (!issue_go && !vld_s1) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// write back the shrunk partition together with the result
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					free_we  = found_q;
					free_wa  = pick_q;
					free_wd  = new_val;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// read pointer and read tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue_go;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= issue_q[AW-1:0];
		if (s_acc) begin
			issue_q <= '0;
			req_q   <= in_size_ext;
			if (in_func == FUNC_ALLOC) begin
				limit_q <= scan_count;
			end else begin
				limit_q <= CW'(MAX_BLOCKS);
			end
		end else if (issue_go) begin
			issue_q <= issue_q + 1'b1;
		end
	end

	// shared compare unit: one entry per cycle against the request and the pick
	logic fits;
	logic better;

	assign fits = (VW'(free_rd_q) >= req_q);
	always_comb begin
		unique case (fit_mode_q)
			MODE_BEST:  better = (free_rd_q < pick_val_q);
			MODE_WORST: better = (free_rd_q > pick_val_q);
			default:    better = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (s_acc) begin
			found_q <= 1'b0;
		end else if ((state_q == ST_SCAN) && vld_s1 && fits && !found_q) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_SCAN) && vld_s1 && fits && (!found_q || better)) begin
			pick_q     <= idx_s1;
			pick_val_q <= free_rd_q;
		end
	end

	// partition memories, registered reads
	always_ff @(posedge clk) begin
		if (free_we) begin
			free_mem[free_wa] <= free_wd;
		end
		free_rd_q <= free_mem[issue_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (orig_we) begin
			orig_mem[load_addr] <= load_wd;
		end
		orig_rd_q <= orig_mem[issue_q[AW-1:0]];
	end

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	logic [IW-1:0] pick_ext;
	logic [VW-1:0] rem_ext;

	assign pick_ext = IW'(pick_q);
	assign rem_ext  = VW'(new_val);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (found_q) begin
				m_tdata_q <= OUT_DATA_BITS'({rem_ext[SIZEF_BITS-1:0],
					pick_ext[INDEX_BITS-1:0], 1'b1});
			end else begin
				m_tdata_q <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the fit memory allocator
// Drives load, allocate, restore and unused requests through the s_* stream
// under first, best, worst fit and the unused mode, with several partition
// counts. A scoreboard keeps its own partition table, predicts each result
// on acceptance and compares the m_* stream against it field by field.
// ----------------------------------------------------------------------------
import fma_pkg::*;

typedef struct packed {
	logic [FUNC_BITS-1:0]  func;
	logic [INDEX_BITS-1:0] block_index;
	logic [SIZEF_BITS-1:0] size_value;
} alloc_req_t;

typedef struct packed {
	logic                  granted;
	logic [INDEX_BITS-1:0] chosen_block;
	logic [SIZEF_BITS-1:0] remaining_size;
} alloc_res_t;

class alloc_scoreboard;
	logic [SIZEF_BITS-1:0] orig_sz [MAX_BLOCKS_DEF];
	logic [SIZEF_BITS-1:0] free_sz [MAX_BLOCKS_DEF];
	logic [MODE_BITS-1:0]  fit_mode;
	logic [COUNT_BITS-1:0] block_count;
	alloc_res_t            pending_grants[$];
	int unsigned           mismatches;
	int unsigned           n_load, n_alloc, n_restore, n_unused, n_granted, n_checked;

	function new();
		foreach (orig_sz[i]) begin
			orig_sz[i] = '0;
			free_sz[i] = '0;
		end
		fit_mode    = MODE_FIRST;
		block_count = BLOCK_COUNT_RST;
		mismatches  = 0;
		n_load = 0; n_alloc = 0; n_restore = 0; n_unused = 0;
		n_granted = 0; n_checked = 0;
	endfunction

	function void write_reg(cfg_reg_t r, logic [CFG_DATA_BITS-1:0] v);
		if (r == REG_FIT_MODE) fit_mode = v[MODE_BITS-1:0];
		else block_count = v[COUNT_BITS-1:0];
	endfunction

	// partitions actually searched: count saturates at the table size
	function int unsigned search_limit();
		return (block_count > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : block_count;
	endfunction

	// apply one request to the table and work out its result
	function alloc_res_t place_request(alloc_req_t q);
		alloc_res_t  r;
		bit          found;
		int unsigned pick;
		r     = '0;
		found = 0;
		pick  = 0;
		case (q.func)
			FUNC_LOAD: begin
				orig_sz[q.block_index] = q.size_value;
				free_sz[q.block_index] = q.size_value;
				n_load++;
			end
			FUNC_RESTORE: begin
				free_sz = orig_sz;
				n_restore++;
			end
			FUNC_ALLOC: begin
				n_alloc++;
				for (int unsigned j = 0; j < search_limit(); j++) begin
					if (free_sz[j] >= q.size_value) begin
						if (!found) begin
							found = 1;
							pick  = j;
							// first fit, and the unused mode, stop at the first hit
							if (fit_mode != MODE_BEST && fit_mode != MODE_WORST) break;
						end else if (fit_mode == MODE_BEST && free_sz[j] < free_sz[pick]) begin
							pick = j;
						end else if (fit_mode == MODE_WORST && free_sz[j] > free_sz[pick]) begin
							pick = j;
						end
					end
				end
				if (found) begin
					free_sz[pick]    = free_sz[pick] - q.size_value;
					r.granted        = 1'b1;
					r.chosen_block   = pick[INDEX_BITS-1:0];
					r.remaining_size = free_sz[pick];
					n_granted++;
				end
			end
			default: n_unused++;
		endcase
		return r;
	endfunction

	function void note_request(alloc_req_t q);
		pending_grants.push_back(place_request(q));
	endfunction

	function void check_result(logic [OUT_DATA_BITS-1:0] d);
		alloc_res_t exp_r, got;
		got = '{granted: d[0], chosen_block: d[INDEX_BITS:1],
			remaining_size: d[INDEX_BITS+SIZEF_BITS:INDEX_BITS+1]};
		if (pending_grants.size() == 0) begin
			$display("%0t: unexpected result, got %0h", $time, got);
			mismatches++;
			return;
		end
		exp_r = pending_grants.pop_front();
		n_checked++;
		if (got.granted !== exp_r.granted) begin
			$display("%0t: granted expected %0h got %0h", $time, exp_r.granted, got.granted);
			mismatches++;
		end
		if (got.chosen_block !== exp_r.chosen_block) begin
			$display("%0t: chosen_block expected %0d got %0d", $time,
				exp_r.chosen_block, got.chosen_block);
			mismatches++;
		end
		if (got.remaining_size !== exp_r.remaining_size) begin
			$display("%0t: remaining_size expected %0h got %0h", $time,
				exp_r.remaining_size, got.remaining_size);
			mismatches++;
		end
	endfunction
endclass

module tb_top;

	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int unsigned HOLD_CYCLES  = 300;   // long receiver hold-off
	localparam int unsigned DRAIN_CYCLES = 80;    // a bit over one full scan
	localparam int unsigned IDLE_PAUSE   = 4;
	localparam int unsigned PHASE_ITEMS  = 152;
	localparam int unsigned N_PHASES     = 10;

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata;   // func[1:0], block_index[7:2], size_value[23:8]
	logic                     m_tvalid;
	logic                     m_tready;
	logic [OUT_DATA_BITS-1:0] m_tdata;   // granted[0], chosen_block[6:1],
	                                     // remaining_size[22:7], zero pad
	logic                     cfg_we;
	logic [CFG_ADDR_BITS-1:0] cfg_addr;
	logic [CFG_DATA_BITS-1:0] cfg_wdata;

	alloc_scoreboard sb;
	bit              steady;     // no gaps on either side while set
	bit              hold_req;   // asks the receiver for one long hold-off
	int unsigned     cycle_cnt;
	int unsigned     n_settings;

	fit_memory_allocator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	// 12 ns clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("simulation failed");
			$finish;
		end
	end

	// mostly zero or short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady || r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// result side: random stalls, plus one long hold when asked
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		m_tready   = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 0;
			end
			if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else begin
				stall_left = pick_gap();
				m_tready   = (stall_left == 0);
				if (stall_left > 0) stall_left--;
			end
		end
	end

	// every accepted result is checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	// offer one request; it is noted in the scoreboard on acceptance
	task automatic send_request(logic [FUNC_BITS-1:0] f, logic [INDEX_BITS-1:0] idx,
		logic [SIZEF_BITS-1:0] sz);
		int unsigned gap;
		alloc_req_t  q;
		q   = '{func: f, block_index: idx, size_value: sz};
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = IN_DATA_BITS'({q.size_value, q.block_index, q.func});
		do @(posedge clk); while (!s_tready);
		sb.note_request(q);
		@(negedge clk);
	endtask

	// wait until every prediction has been matched, then let the block settle
	task automatic wait_idle();
		s_tvalid = 1'b0;
		while (sb.pending_grants.size() != 0) @(posedge clk);
		repeat (IDLE_PAUSE) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_BITS-1:0] v);
		cfg_we    = 1'b1;
		cfg_addr  = r;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we    = 1'b0;
		sb.write_reg(r, v);
	endtask

	// partition sizes: some extremes, some repeated values for ties
	function automatic logic [SIZEF_BITS-1:0] pick_part_size();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 5) return '0;
		if (r < 10) return '1;
		if (r < 45) return 16'(100 * $urandom_range(1, 4));
		return 16'($urandom_range(0, 65535));
	endfunction

	// request sizes: mostly something a searched partition can hold
	function automatic logic [SIZEF_BITS-1:0] pick_req_size();
		int unsigned r, lim, j;
		r   = $urandom_range(0, 99);
		lim = sb.search_limit();
		j   = $urandom_range(0, (lim == 0) ? 0 : lim - 1);
		if (r < 8) return '0;
		if (r < 12) return '1;
		if (r < 80) return 16'($urandom_range(0, sb.free_sz[j]));
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic random_request();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			send_request(FUNC_ALLOC, 6'($urandom_range(0, 63)), pick_req_size());
		else if (r < 85)
			send_request(FUNC_LOAD, 6'($urandom_range(0, 63)), pick_part_size());
		else if (r < 93)
			send_request(FUNC_RESTORE, 6'($urandom_range(0, 63)), 16'($urandom_range(0, 65535)));
		else
			send_request(2'd3, 6'($urandom_range(0, 63)), 16'($urandom_range(0, 65535)));
	endtask

	// fixed opening sequence: extremes, zero-size fit, unused code, restore
	task automatic directed_requests();
		send_request(FUNC_LOAD, 6'd0, 16'h0000);
		send_request(FUNC_ALLOC, 6'd0, 16'h0000);    // zero size fits an empty partition
		send_request(FUNC_LOAD, 6'd63, 16'hFFFF);
		send_request(FUNC_ALLOC, 6'd63, 16'hFFFF);
		send_request(FUNC_ALLOC, 6'd0, 16'hFFFF);    // likely nothing left that big
		send_request(FUNC_ALLOC, 6'd0, 16'h0001);
		send_request(2'd3, 6'd63, 16'hFFFF);         // unused code changes nothing
		send_request(FUNC_RESTORE, 6'd0, 16'h0000);
		send_request(FUNC_LOAD, 6'h2A, 16'h5555);
		send_request(FUNC_LOAD, 6'h15, 16'hAAAA);
		send_request(FUNC_ALLOC, 6'd0, 16'hAAAA);
		send_request(FUNC_ALLOC, 6'd0, 16'h5555);
		send_request(FUNC_ALLOC, 6'd0, 16'h5555);
		send_request(FUNC_RESTORE, 6'h3F, 16'hFFFF);
		send_request(FUNC_ALLOC, 6'd0, 16'h0000);
		send_request(FUNC_ALLOC, 6'd0, 16'hFFFF);
		send_request(2'd3, 6'd0, 16'h0000);
		send_request(FUNC_ALLOC, 6'd0, 16'h8000);
	endtask

	initial begin
		logic [MODE_BITS-1:0]  ph_mode  [N_PHASES];
		logic [COUNT_BITS-1:0] ph_count [N_PHASES];

		// settings per phase; count 0, 1, 64 and above 64 are the edges
		ph_mode  = '{MODE_FIRST, MODE_BEST, MODE_WORST, 2'd3, MODE_BEST,
			MODE_WORST, MODE_FIRST, MODE_BEST, MODE_WORST, MODE_FIRST};
		ph_count = '{7'd64, 7'd64, 7'd64, 7'd64, 7'd1, 7'd0, 7'd127, 7'd65,
			7'($urandom_range(2, 63)), 7'($urandom_range(1, 64))};

		sb         = new();
		cycle_cnt  = 0;
		n_settings = 0;
		steady     = 0;
		hold_req   = 0;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		cfg_we     = 1'b0;
		cfg_addr   = REG_FIT_MODE;
		cfg_wdata  = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// every partition gets loaded before anything reads the table
		for (int i = 0; i < MAX_BLOCKS_DEF; i++)
			send_request(FUNC_LOAD, 6'(i), pick_part_size());

		for (int p = 0; p < N_PHASES; p++) begin
			wait_idle();
			// junk in the upper data bits of a mode write is dropped
			write_reg(REG_FIT_MODE, {5'($urandom_range(0, 31)), ph_mode[p]});
			write_reg(REG_BLOCK_COUNT, ph_count[p]);
			n_settings++;
			steady = (p == 3);
			if (p == 0) directed_requests();
			if (p == 2) hold_req = 1;   // block fills up behind a stalled receiver
			for (int k = 0; k < PHASE_ITEMS; k++) random_request();
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("requests: %0d load, %0d allocate (%0d granted), %0d restore, %0d unused",
			sb.n_load, sb.n_alloc, sb.n_granted, sb.n_restore, sb.n_unused);
		$display("%0d fit/count settings, %0d results checked, %0d mismatches",
			n_settings, sb.n_checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_grants.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/fma_pkg.sv
rtl/core/fit_memory_allocator.sv
tb/tb_top.sv
